### rtl/isa_pkg.sv
package isa_pkg;

    localparam int ADDR_BITS = 32;
    localparam int ZB_BITS   = 5;
    localparam int NUM_BITS  = 8;
    localparam int DEN_BITS  = 9;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_ZERO = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_ZERO = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FILL_NUM = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FILL_DEN = 2'd3;

    localparam logic [ZB_BITS-1:0]  MIN_ZERO_RST = 5'd2;
    localparam logic [ZB_BITS-1:0]  MAX_ZERO_RST = 5'd10;
    localparam logic [NUM_BITS-1:0] FILL_NUM_RST = 8'd3;
    localparam logic [DEN_BITS-1:0] FILL_DEN_RST = 9'd4;

    typedef enum logic [2:0] {
        ST_LOADED    = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_EMITTED   = 3'd3,
        ST_EXHAUSTED = 3'd4
    } isa_status_e;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_INS,
        S_SH_RD,
        S_SH_WR,
        S_E_RD,
        S_E_FIRST,
        S_Z,
        S_SKIP,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_EVAL,
        S_QUAL,
        S_RES
    } isa_state_e;

    typedef struct packed {
        logic        capture;
        logic        srch_rd;
        logic        srch_adv;
        logic        shift_init;
        logic        shift_rd;
        logic        shift_wr;
        logic        insert;
        logic        emit_rd;
        logic        first_ld;
        logic        mul_ld;
        logic        z_dec;
        logic        scan_init;
        logic        scan_rd;
        logic        scan_adv;
        logic        qprod_ld;
        logic        best_ld;
        logic        code_ld;
        isa_status_e code;
        logic        res_wr;
    } isa_cmd_t;

    typedef struct packed {
        logic empty_read;
        logic idx_at_end;
        logic data_lt;
        logic data_eq;
        logic full;
        logic shift_done;
        logic z_done;
        logic skip;
        logic scan_end;
        logic data_le_end;
        logic ct_one;
        logic qualify;
        logic best_ok;
        logic out_free;
    } isa_sts_t;

endpackage

### rtl/isa_if.sv
interface isa_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] address;
    modport source (output valid, cmd, address, input ready);
    modport sink   (input valid, cmd, address, output ready);
endinterface

interface isa_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] base_address;
    logic [5:0]  prefix_length;
    modport source (output valid, status, base_address, prefix_length, input ready);
    modport sink   (input valid, status, base_address, prefix_length, output ready);
endinterface

interface isa_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [8:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/ipv4_subnet_aggregator.sv
// Load: a linear search through the entries below the insertion point, then a shift of
// each entry above it by one place (one RAM port each way).
// Emit: per host-bit count tried, a fill check, then a scan of each covered entry. One
// request is worked at a time; a result waits in an output register while the next
// request is taken.
// Reset clears counts, read position, output valid and restores the configuration defaults.
module ipv4_subnet_aggregator import isa_pkg::*; #(
    parameter int STORE_DEPTH = 1024
) (
    input  logic    clk,
    input  logic    rst_n,
    isa_req_if.sink   req,
    isa_rsp_if.source rsp,
    isa_cfg_if.sink   cfg
);

    isa_cmd_t cmd;
    isa_sts_t sts;

    isa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_cmd   (req.cmd),
        .sts       (sts),
        .req_ready (req.ready),
        .cmd       (cmd)
    );

    isa_datapath #(.STORE_DEPTH(STORE_DEPTH)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_address (req.address),
        .cmd         (cmd),
        .sts         (sts),
        .rsp         (rsp),
        .cfg         (cfg)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while busy");

    a_res_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_wr |-> sts.out_free)
        else $error("result written over a pending one");

    a_res_shows_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_wr |=> rsp.valid)
        else $error("result not presented");

endmodule

### rtl/isa_ram.sv
module isa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/isa_ctrl.sv
module isa_ctrl import isa_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  logic     req_cmd,
    input  isa_sts_t sts,
    output logic     req_ready,
    output isa_cmd_t cmd
);

    isa_state_e state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (!req_cmd)
                        state_next = S_SRCH_RD;
                    else if (sts.empty_read)
                        state_next = S_RES;
                    else
                        state_next = S_E_RD;
                end
            end
            S_SRCH_RD:  state_next = sts.idx_at_end ? S_INS : S_SRCH_CMP;
            S_SRCH_CMP:
            begin
                if (sts.data_eq)
                    state_next = S_RES;
                else if (sts.data_lt)
                    state_next = S_SRCH_RD;
                else
                    state_next = S_INS;
            end
            S_INS:      state_next = sts.full ? S_RES : S_SH_RD;
            S_SH_RD:    state_next = sts.shift_done ? S_RES : S_SH_WR;
            S_SH_WR:    state_next = S_SH_RD;
            S_E_RD:     state_next = S_E_FIRST;
            S_E_FIRST:  state_next = S_Z;
            S_Z:        state_next = sts.z_done ? S_RES : S_SKIP;
            S_SKIP:     state_next = sts.skip ? S_Z : S_SCAN_RD;
            S_SCAN_RD:  state_next = sts.scan_end ? S_EVAL : S_SCAN_CMP;
            S_SCAN_CMP: state_next = sts.data_le_end ? S_SCAN_RD : S_EVAL;
            S_EVAL:     state_next = sts.ct_one ? S_RES : S_QUAL;
            S_QUAL:
            begin
                if (sts.qualify && !sts.best_ok)
                    state_next = S_RES;
                else
                    state_next = S_Z;
            end
            S_RES:      state_next = sts.out_free ? S_IDLE : S_RES;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        cmd.code  = ST_LOADED;
        req_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    if (req_cmd && sts.empty_read)
                    begin
                        cmd.code_ld = 1'b1;
                        cmd.code    = ST_EXHAUSTED;
                    end
                end
            end
            S_SRCH_RD:  cmd.srch_rd = !sts.idx_at_end;
            S_SRCH_CMP:
            begin
                if (sts.data_eq)
                begin
                    cmd.code_ld = 1'b1;
                    cmd.code    = ST_DUPLICATE;
                end
                else if (sts.data_lt)
                begin
                    cmd.srch_adv = 1'b1;
                end
            end
            S_INS:
            begin
                if (sts.full)
                begin
                    cmd.code_ld = 1'b1;
                    cmd.code    = ST_FULL;
                end
                else
                begin
                    cmd.shift_init = 1'b1;
                end
            end
            S_SH_RD:
            begin
                if (sts.shift_done)
                begin
                    cmd.insert  = 1'b1;
                    cmd.code_ld = 1'b1;
                    cmd.code    = ST_LOADED;
                end
                else
                begin
                    cmd.shift_rd = 1'b1;
                end
            end
            S_SH_WR:    cmd.shift_wr = 1'b1;
            S_E_RD:     cmd.emit_rd  = 1'b1;
            S_E_FIRST:  cmd.first_ld = 1'b1;
            S_Z:
            begin
                if (sts.z_done)
                begin
                    cmd.code_ld = 1'b1;
                    cmd.code    = ST_EMITTED;
                end
                else
                begin
                    cmd.mul_ld = 1'b1;
                end
            end
            S_SKIP:
            begin
                cmd.z_dec     = sts.skip;
                cmd.scan_init = !sts.skip;
            end
            S_SCAN_RD:  cmd.scan_rd  = !sts.scan_end;
            S_SCAN_CMP: cmd.scan_adv = sts.data_le_end;
            S_EVAL:
            begin
                if (sts.ct_one)
                begin
                    cmd.code_ld = 1'b1;
                    cmd.code    = ST_EMITTED;
                end
                else
                begin
                    cmd.qprod_ld = 1'b1;
                end
            end
            S_QUAL:
            begin
                if (sts.qualify && !sts.best_ok)
                begin
                    cmd.code_ld = 1'b1;
                    cmd.code    = ST_EMITTED;
                end
                else
                begin
                    cmd.best_ld = sts.qualify;
                    cmd.z_dec   = 1'b1;
                end
            end
            S_RES:      cmd.res_wr = sts.out_free;
            default:    cmd = '0;
        endcase
    end

endmodule

### rtl/isa_datapath.sv
module isa_datapath import isa_pkg::*; #(
    parameter int STORE_DEPTH = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [31:0]   req_address,
    input  isa_cmd_t      cmd,
    output isa_sts_t      sts,
    isa_rsp_if.source     rsp,
    isa_cfg_if.sink       cfg
);

    localparam int AW  = $clog2(STORE_DEPTH);
    localparam int CW  = $clog2(STORE_DEPTH + 1);
    localparam int OW  = ADDR_BITS - 1 + DEN_BITS;
    localparam int XW  = OW + 2;
    localparam int QPW = CW + 1 + DEN_BITS;
    localparam int YW  = NUM_BITS + ADDR_BITS - 1;
    localparam int QW  = (QPW > YW) ? QPW : YW;
    localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

    logic [ZB_BITS-1:0]   min_z_reg, max_z_reg;
    logic [NUM_BITS-1:0]  num_reg;
    logic [DEN_BITS-1:0]  den_reg;
    logic [CW-1:0]        count_reg, rp_reg;
    logic                 out_valid_reg;
    logic [2:0]           out_status_reg;
    logic [31:0]          out_base_reg;
    logic [5:0]           out_prefix_reg;

    logic [31:0]          addr_reg, first_reg;
    logic [CW-1:0]        idx_reg, j_reg, p_reg, ct_reg, best_ct_reg, pos_end_reg;
    logic [5:0]           z_reg;
    logic [ZB_BITS-1:0]   best_z_reg;
    logic [OW-1:0]        prod_o_reg;
    logic [QPW-1:0]       qprod_reg;
    isa_status_e          code_reg;

    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [31:0]          ram_wdata, rdata;

    logic [DEN_BITS-1:0]  den_eff;
    logic [31:0]          low_mask, best_low;
    logic signed [10:0]   diff;
    logic signed [XW-1:0] xs, neg_xs;
    logic [YW-1:0]        y_val;
    logic [CW-1:0]        j_dec;

    assign den_eff  = (den_reg == '0) ? DEN_BITS'(1) : den_reg;
    assign low_mask = (32'h1 << z_reg[4:0]) - 32'h1;
    assign best_low = (32'h1 << best_z_reg) - 32'h1;
    assign diff     = $signed({2'b00, den_eff}) - $signed({3'b000, num_reg});
    assign xs       = XW'(diff) <<< z_reg[4:0];
    assign neg_xs   = -xs;
    assign y_val    = YW'(num_reg) << z_reg[4:0];
    assign j_dec    = j_reg - CW'(1);

    always_comb
    begin
        sts.empty_read  = rp_reg >= count_reg;
        sts.idx_at_end  = idx_reg == count_reg;
        sts.data_lt     = rdata < addr_reg;
        sts.data_eq     = rdata == addr_reg;
        sts.full        = count_reg >= DEPTH_C;
        sts.shift_done  = j_reg == idx_reg;
        sts.z_done      = z_reg[5] || (z_reg[4:0] < min_z_reg);
        if (!xs[XW-1])
            sts.skip = xs < $signed({2'b00, prod_o_reg});
        else
            sts.skip = (prod_o_reg != '0) ||
                       (neg_xs >= $signed({(XW-DEN_BITS)'(0), den_eff}));
        sts.scan_end    = p_reg >= count_reg;
        sts.data_le_end = rdata <= (first_reg | low_mask);
        sts.ct_one      = ct_reg == CW'(1);
        sts.qualify     = QW'(qprod_reg) > QW'(y_val);
        sts.best_ok     = (best_ct_reg == '0) || (ct_reg == best_ct_reg);
        sts.out_free    = !out_valid_reg || rsp.ready;
    end

    always_comb
    begin
        ram_re    = cmd.srch_rd || cmd.shift_rd || cmd.emit_rd || cmd.scan_rd;
        ram_raddr = idx_reg[AW-1:0];
        if (cmd.shift_rd)
            ram_raddr = j_dec[AW-1:0];
        else if (cmd.emit_rd)
            ram_raddr = rp_reg[AW-1:0];
        else if (cmd.scan_rd)
            ram_raddr = p_reg[AW-1:0];
        ram_we    = cmd.shift_wr || cmd.insert;
        ram_waddr = cmd.shift_wr ? j_reg[AW-1:0] : idx_reg[AW-1:0];
        ram_wdata = cmd.shift_wr ? rdata : addr_reg;
    end

    isa_ram #(.WIDTH(ADDR_BITS), .DEPTH(STORE_DEPTH)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    assign cfg.ready         = 1'b1;
    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.base_address  = out_base_reg;
    assign rsp.prefix_length = out_prefix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_z_reg     <= MIN_ZERO_RST;
            max_z_reg     <= MAX_ZERO_RST;
            num_reg       <= FILL_NUM_RST;
            den_reg       <= FILL_DEN_RST;
            count_reg     <= '0;
            rp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_MIN_ZERO: min_z_reg <= cfg.data[ZB_BITS-1:0];
                    CFG_MAX_ZERO: max_z_reg <= cfg.data[ZB_BITS-1:0];
                    CFG_FILL_NUM: num_reg   <= cfg.data[NUM_BITS-1:0];
                    CFG_FILL_DEN: den_reg   <= cfg.data;
                    default:      num_reg   <= num_reg;
                endcase
            end
            if (cmd.insert)
                count_reg <= count_reg + CW'(1);
            if (cmd.res_wr && code_reg == ST_EMITTED)
                rp_reg <= (best_z_reg != '0) ? pos_end_reg : rp_reg + CW'(1);
            if (cmd.res_wr)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            addr_reg <= req_address;
            idx_reg  <= '0;
        end
        if (cmd.srch_adv)
            idx_reg <= idx_reg + CW'(1);
        if (cmd.shift_init)
            j_reg <= count_reg;
        if (cmd.shift_wr)
            j_reg <= j_dec;
        if (cmd.emit_rd)
        begin
            z_reg       <= {1'b0, max_z_reg};
            best_ct_reg <= '0;
            best_z_reg  <= '0;
        end
        if (cmd.first_ld)
            first_reg <= rdata;
        // Offset of the first address inside the subnet, scaled by the denominator.
        if (cmd.mul_ld)
            prod_o_reg <= (first_reg[30:0] & low_mask[30:0]) * den_eff;
        if (cmd.z_dec)
            z_reg <= z_reg - 6'd1;
        if (cmd.scan_init)
        begin
            p_reg  <= rp_reg + CW'(1);
            ct_reg <= CW'(1);
        end
        if (cmd.scan_adv)
        begin
            p_reg  <= p_reg + CW'(1);
            ct_reg <= ct_reg + CW'(1);
        end
        if (cmd.qprod_ld)
            qprod_reg <= ({1'b0, ct_reg} + (CW+1)'(1)) * den_eff;
        if (cmd.best_ld)
        begin
            best_ct_reg <= ct_reg;
            best_z_reg  <= z_reg[4:0];
            pos_end_reg <= p_reg;
        end
        if (cmd.code_ld)
            code_reg <= cmd.code;
        if (cmd.res_wr)
        begin
            out_status_reg <= code_reg;
            out_base_reg   <= '0;
            out_prefix_reg <= '0;
            if (code_reg == ST_EMITTED)
            begin
                out_base_reg   <= first_reg & ~best_low;
                out_prefix_reg <= 6'd32 - {1'b0, best_z_reg};
            end
        end
    end

endmodule

### tb/sv/ipv4_subnet_aggregator_tb.sv
`timescale 1ns / 100ps

module ipv4_subnet_aggregator_tb;
    import isa_pkg::*;

    localparam int DEPTH       = 256;
    localparam int NUM_ITEMS   = 580;
    localparam longint LIMIT   = 50_000_000;

    typedef struct {
        isa_status_e status;
        bit [31:0]   base;
        bit [5:0]    prefix;
    } subnet_result_t;

    class subnet_scoreboard;
        bit [31:0]      store[$];
        int unsigned    depth;
        int unsigned    rd_pos;
        bit [4:0]       min_z;
        bit [4:0]       max_z;
        bit [7:0]       num;
        bit [8:0]       den;
        subnet_result_t pending[$];
        int             mismatches;
        int             checked;
        int             status_seen[5];

        function new(int unsigned d);
            depth  = d;
            rd_pos = 0;
            min_z  = MIN_ZERO_RST;
            max_z  = MAX_ZERO_RST;
            num    = FILL_NUM_RST;
            den    = FILL_DEN_RST;
            mismatches = 0;
            checked    = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void write_reg(bit [1:0] idx, bit [8:0] d);
            case (idx)
                CFG_MIN_ZERO: min_z = d[4:0];
                CFG_MAX_ZERO: max_z = d[4:0];
                CFG_FILL_NUM: num   = d[7:0];
                CFG_FILL_DEN: den   = d;
                default: ;
            endcase
        endfunction

        function subnet_result_t aggregate(bit cmd, bit [31:0] a);
            subnet_result_t r;
            int unsigned    i;
            int unsigned    pos;
            int unsigned    p;
            int unsigned    ct;
            int unsigned    best_ct;
            int unsigned    best_z;
            int unsigned    pos_end;
            bit [31:0]      lead_addr;
            bit [31:0]      mask;
            bit [31:0]      start_addr;
            bit [31:0]      end_addr;
            longint         n;
            longint         d;
            longint         span;
            int             z;
            r.status = ST_LOADED;
            r.base   = '0;
            r.prefix = '0;
            if (cmd == 1'b0) begin
                i = 0;
                while (i < store.size() && store[i] < a) i++;
                if (i < store.size() && store[i] == a)
                    r.status = ST_DUPLICATE;
                else if (store.size() >= depth)
                    r.status = ST_FULL;
                else
                    store.insert(i, a);
                return r;
            end
            if (rd_pos >= store.size()) begin
                r.status = ST_EXHAUSTED;
                return r;
            end
            pos       = rd_pos;
            lead_addr = store[pos];
            n         = longint'(num);
            d         = (den == 0) ? 64'sd1 : longint'(den);
            best_ct   = 0;
            best_z    = 0;
            pos_end   = pos + 1;
            for (z = int'(max_z); z >= int'(min_z); z--) begin
                mask       = ~((32'd1 << z) - 32'd1);
                start_addr = lead_addr & mask;
                end_addr   = start_addr | ~mask;
                span       = 64'sd1 << z;
                if (longint'({32'd0, lead_addr}) >
                    longint'({32'd0, start_addr}) + span * (d - n) / d)
                    continue;
                p  = pos + 1;
                ct = 1;
                while (p < store.size() && store[p] <= end_addr) begin
                    p++;
                    ct++;
                end
                if (ct == 1) break;
                if (longint'(ct) >= span * n / d) begin
                    if (best_ct == 0 || ct == best_ct) begin
                        best_ct = ct;
                        best_z  = z;
                        pos_end = p;
                    end else begin
                        break;
                    end
                end
            end
            if (best_z != 0) begin
                r.base = lead_addr & ~((32'd1 << best_z) - 32'd1);
            end else begin
                r.base  = lead_addr;
                pos_end = pos + 1;
            end
            r.status = ST_EMITTED;
            r.prefix = 6'(32 - best_z);
            rd_pos   = pos_end;
            return r;
        endfunction

        function void note_request(bit cmd, bit [31:0] a);
            pending.push_back(aggregate(cmd, a));
        endfunction

        function void check_response(bit [2:0] st, bit [31:0] base, bit [5:0] prefix);
            subnet_result_t e;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response: status %0d base %h prefix %0d",
                             st, base, prefix);
                return;
            end
            e = pending.pop_front();
            if (st < 5) status_seen[st]++;
            if (st != e.status || base != e.base || prefix != e.prefix) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected status %0d base %h /%0d, got %0d %h /%0d",
                             e.status, e.base, e.prefix, st, base, prefix);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    isa_req_if req ();
    isa_rsp_if rsp ();
    isa_cfg_if cfg ();

    ipv4_subnet_aggregator #(.STORE_DEPTH(DEPTH)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    subnet_scoreboard sb = new(DEPTH);

    longint cycles     = 0;
    int     n_items    = 0;
    int     n_loads    = 0;
    int     n_emits    = 0;
    int     n_phases   = 0;
    int     burst_left = 0;
    int     stall_mode = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        req.valid   = 1'b0;
        req.cmd     = 1'b0;
        req.address = '0;
        cfg.valid   = 1'b0;
        cfg.index   = '0;
        cfg.data    = '0;
        rsp.ready   = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver stall pattern follows the mode picked for the current phase.
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
            sb.check_response(rsp.status, rsp.base_address, rsp.prefix_length);
        case (stall_mode)
            0: rsp.ready <= 1'b1;
            1: rsp.ready <= ($urandom_range(0, 3) != 0);
            2: rsp.ready <= ((cycles % 7) < 4);
            default: rsp.ready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    task automatic send_req(bit c, bit [31:0] a);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        req.valid   <= 1'b1;
        req.cmd     <= c;
        req.address <= a;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        sb.note_request(c, a);
        burst_left--;
        n_items++;
        if (c) n_emits++;
        else n_loads++;
    endtask

    // Drop valid and hold until every request has its response.
    task automatic drain();
        req.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_reg(bit [1:0] idx, bit [8:0] d);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= d;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        cfg.valid <= 1'b0;
        sb.write_reg(idx, d);
        @(posedge clk);
    endtask

    task automatic set_all(bit [4:0] mn, bit [4:0] mx, bit [7:0] nu, bit [8:0] de);
        set_reg(CFG_MIN_ZERO, {4'($urandom_range(0, 15)), mn});
        set_reg(CFG_MAX_ZERO, {4'($urandom_range(0, 15)), mx});
        set_reg(CFG_FILL_NUM, {1'($urandom_range(0, 1)), nu});
        set_reg(CFG_FILL_DEN, de);
    endtask

    task automatic random_config();
        int       r;
        bit [4:0] mn;
        bit [4:0] mx;
        bit [8:0] de;
        r = $urandom_range(0, 9);
        case (r)
            0: set_all(5'd1, 5'd31, 8'($urandom_range(1, 255)), 9'd256);
            1: set_all(5'd31, 5'd1, 8'd3, 9'd4);
            2: set_all(5'($urandom_range(1, 4)), 5'($urandom_range(6, 12)), 8'd255, 9'd256);
            3: set_all(5'd2, 5'd10, 8'($urandom_range(0, 255)), 9'd0);
            4: set_all(5'($urandom_range(1, 3)), 5'($urandom_range(4, 12)),
                       8'($urandom_range(8, 255)), 9'($urandom_range(1, 8)));
            5: set_all(5'd0, 5'($urandom_range(0, 10)), 8'd1, 9'd2);
            default: begin
                mn = 5'($urandom_range(1, 6));
                mx = 5'($urandom_range(mn, 12));
                de = 9'($urandom_range(2, 16));
                set_all(mn, mx, 8'($urandom_range(1, de - 1)), de);
            end
        endcase
    endtask

    initial
    begin
        int        i;
        int        n;
        int        r;
        int        hb;
        bit [31:0] base;
        bit [31:0] hmask;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset configuration, extremes, duplicates, exhausted list.
        send_req(1'b1, 32'hFFFF_FFFF);
        send_req(1'b0, 32'h0000_0000);
        send_req(1'b0, 32'hFFFF_FFFF);
        send_req(1'b0, 32'h0000_0000);
        for (i = 1; i < 8; i++) send_req(1'b0, 32'h0A00_0000 | i);
        send_req(1'b1, 32'h0);
        send_req(1'b1, 32'h0);
        send_req(1'b1, 32'h0);
        send_req(1'b1, 32'h0);
        send_req(1'b1, 32'h0);
        drain();
        // Load below the read position, then max below min.
        set_all(5'd31, 5'd1, 8'd3, 9'd4);
        send_req(1'b0, 32'h0500_0000);
        send_req(1'b0, 32'hC0A8_0101);
        send_req(1'b0, 32'hC0A8_0102);
        send_req(1'b1, 32'h0);
        send_req(1'b1, 32'h0);
        drain();
        // Zero host bits, zero denominator, numerator above denominator.
        set_all(5'd0, 5'd0, 8'd255, 9'd0);
        send_req(1'b0, 32'hC0A8_0103);
        send_req(1'b1, 32'h0);
        drain();
        set_all(5'd1, 5'd31, 8'd255, 9'd3);
        send_req(1'b1, 32'h0);
        send_req(1'b1, 32'h0);
        drain();

        while (n_items < NUM_ITEMS) begin
            n_phases++;
            stall_mode = $urandom_range(0, 3);
            random_config();
            n    = $urandom_range(4, 30);
            base = $urandom;
            hb   = $urandom_range(2, 10);
            hmask = (32'd1 << hb) - 32'd1;
            for (i = 0; i < n; i++) begin
                r = $urandom_range(0, 99);
                if (r < 65)
                    send_req(1'b0, (base & ~hmask) | ($urandom & hmask));
                else if (r < 75)
                    send_req(1'b0, $urandom);
                else if (r < 82 && sb.store.size() != 0)
                    send_req(1'b0, sb.store[$urandom_range(0, sb.store.size() - 1)]);
                else
                    send_req(1'b1, $urandom);
            end
            n = $urandom_range(1, n);
            for (i = 0; i < n; i++) send_req(1'b1, $urandom);
            drain();
        end

        drain();
        repeat (100) @(posedge clk);
        $display("covered %0d requests (%0d loads, %0d emits) over %0d phases",
                 n_items, n_loads, n_emits, n_phases);
        $display("responses: loaded %0d dup %0d full %0d emitted %0d exhausted %0d",
                 sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
                 sb.status_seen[3], sb.status_seen[4]);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
